// File: design/s2k_pkg.sv
// Shared constants, types and helper functions for the seed-to-key block.
`timescale 1ns / 1ps

package s2k_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CfgAddrW = 3;

  localparam logic [DataW-1:0] ConstReset = 32'hD68E_E6A2;
  localparam logic [DataW-1:0] TapMask    = 32'h4100_1004; // taps 30, 24, 12, 2
  localparam logic [7:0]       Mask2Xor   = 8'hA5;
  localparam logic [7:0]       Mask3Xor   = 8'h5A;

  localparam int unsigned SelHiBit  = 11;
  localparam int unsigned SelLoBit  = 21;
  localparam int unsigned PermBit   = 0;

  // Register byte address of the security constant
  localparam logic [CfgAddrW-1:0] RegConstAddr = 3'd0;

  typedef struct packed {
    logic busy;       // an item is in the sequencer
    logic key_valid;  // key word is final and waits for the output register
  } core_stat_t;

  function automatic logic [7:0] pick_byte(input logic [DataW-1:0] seed,
                                           input logic [DataW-1:0] c);
    logic [1:0] sel;
    logic [7:0] b;
    sel = {c[SelHiBit], c[SelLoBit]};
    unique case (sel)
      2'd0:    b = seed[31:24];
      2'd1:    b = seed[23:16];
      2'd2:    b = seed[15:8];
      default: b = seed[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [CountW-1:0] shift_count(input logic [7:0] b,
                                                    input logic [DataW-1:0] c);
    logic [7:0] m1;
    logic [7:0] m2;
    logic [7:0] m3;
    m1 = c[9:2];
    m2 = c[30:23] ^ Mask2Xor;
    m3 = c[20:13] ^ Mask3Xor;
    return ((b ^ m1) & m2) + m3;
  endfunction

  function automatic logic [DataW-1:0] lfsr_step(input logic [DataW-1:0] s);
    return {s[DataW-2:0], ^(s & TapMask)};
  endfunction

  // Byte order L1, L3, L0, L2 from the top down
  function automatic logic [DataW-1:0] permute(input logic [DataW-1:0] s);
    return {s[15:8], s[31:24], s[7:0], s[23:16]};
  endfunction

endpackage

// File: design/s2k_cfg_regs.sv
// APB-style register file holding the security constant.
`timescale 1ns / 1ps

module s2k_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [s2k_pkg::CfgAddrW-1:0]  paddr,
  input  logic [s2k_pkg::DataW-1:0]     pwdata,
  output logic [s2k_pkg::DataW-1:0]     prdata,
  output logic                          pready,
  output logic [s2k_pkg::DataW-1:0]     sec_const
);

  logic [s2k_pkg::DataW-1:0] const_r;
  logic                      hit;

  // Word decode: byte offset bits do not take part
  assign hit       = (paddr[s2k_pkg::CfgAddrW-1:2] ==
                      s2k_pkg::RegConstAddr[s2k_pkg::CfgAddrW-1:2]);
  assign pready    = 1'b1;
  assign prdata    = hit ? const_r : '0;
  assign sec_const = const_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      const_r <= s2k_pkg::ConstReset;
    end else if (psel && penable && pwrite && hit) begin
      const_r <= pwdata;
    end
  end

endmodule

// File: design/s2k_lfsr_core.sv
// Sequencer and shared one-step LFSR unit that iterates the seed.
`timescale 1ns / 1ps

module s2k_lfsr_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [s2k_pkg::DataW-1:0]    seed,
  input  logic [s2k_pkg::DataW-1:0]    sec_const,
  input  logic                         out_free,
  output s2k_pkg::core_stat_t          stat,
  output logic [s2k_pkg::DataW-1:0]    key
);

  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } state_t;

  state_t                     state_r;
  logic [s2k_pkg::DataW-1:0]  lfsr_r;
  logic [s2k_pkg::CountW-1:0] cnt_r;
  logic [s2k_pkg::DataW-1:0]  perm;
  logic                       done;

  assign done = (state_r == ST_SHIFT) && (cnt_r == '0);
  assign perm = sec_const[s2k_pkg::PermBit] ? s2k_pkg::permute(lfsr_r) : lfsr_r;
  assign key  = perm ^ sec_const;

  assign stat.busy      = (state_r != ST_IDLE);
  assign stat.key_valid = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            lfsr_r  <= seed;
            cnt_r   <= s2k_pkg::shift_count(s2k_pkg::pick_byte(seed, sec_const), sec_const);
            state_r <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (cnt_r != '0) begin
            lfsr_r <= s2k_pkg::lfsr_step(lfsr_r);
            cnt_r  <= cnt_r - 1'b1;
          end else if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: design/seed_to_key_lfsr.sv
// Top level of the seed-to-key block: config port, LFSR sequencer, output register.
`timescale 1ns / 1ps
//
// Usage:
// - Input channel in_valid/in_stall/in_seed carries one 32-bit seed per transfer;
//   a transfer happens on a rising edge with in_valid high and in_stall low.
// - Result channel out_valid/out_stall/out_key returns one key per seed, in order.
// - cfg_* is an APB-style port; the security constant sits at byte address 0,
//   pready is always high, writes land in the access cycle. Write it only idle.
// - The selected seed byte gives a step count n (0..255). The LFSR takes one step
//   per cycle in a single shared shift unit, so a seed stays in the sequencer until its
//   n steps are done; the key shows on out_valid in the cycle after its handoff.
// - The sequencer takes a new seed only once it has released the last one; in_stall
//   stays high while the sequencer holds an item.
// - A finished key moves to the output register; the sequencer then takes the
//   next seed while that key still waits on a stalled receiver. If the output
//   register is still full, the sequencer holds its key until it drains.
// - Reset (rst_n low, synchronous) empties the sequencer and the output register
//   and restores the constant to 0xD68EE6A2.
module seed_to_key_lfsr (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [s2k_pkg::DataW-1:0]     in_seed,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [s2k_pkg::DataW-1:0]     out_key,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [s2k_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [s2k_pkg::DataW-1:0]     cfg_pwdata,
  output logic [s2k_pkg::DataW-1:0]     cfg_prdata,
  output logic                          cfg_pready
);

  logic [s2k_pkg::DataW-1:0] sec_const;
  logic [s2k_pkg::DataW-1:0] core_key;
  s2k_pkg::core_stat_t       stat;
  logic                      out_valid_r;
  logic [s2k_pkg::DataW-1:0] out_key_r;
  logic                      out_free;
  logic                      in_xfer;
  logic                      handoff;

  s2k_cfg_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready),
    .sec_const (sec_const)
  );

  // Sequencer is ready only when it holds nothing
  assign in_stall = stat.busy;
  assign in_xfer  = in_valid && !in_stall;

  // Output register can load when empty or when its key leaves this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign handoff  = stat.key_valid && out_free;

  s2k_lfsr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer),
    .seed      (in_seed),
    .sec_const (sec_const),
    .out_free  (out_free),
    .stat      (stat),
    .key       (core_key)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (handoff) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (handoff) begin
      out_key_r <= core_key;
    end
  end

  assign out_valid = out_valid_r;
  assign out_key   = out_key_r;

  // A finished key only exists inside a busy sequencer
  a_key_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.key_valid |-> stat.busy)
    else $error("key_valid without busy sequencer");

  // An accepted seed occupies the sequencer next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> stat.busy)
    else $error("seed accepted but sequencer not busy");

  // A handed-off key is presented next cycle
  a_handoff_shows: assert property (@(posedge clk) disable iff (!rst_n)
    handoff |=> out_valid_r)
    else $error("handed-off key not presented");

  // Sequencer releases only after handing its key to the output register
  a_release_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    stat.key_valid && !out_free |=> stat.busy)
    else $error("sequencer dropped a key");

endmodule

// File: test/tb_seed_to_key_lfsr.sv
// Testbench for seed_to_key_lfsr: key prediction, scoreboard and APB-driven constant changes.
`timescale 1ns / 1ps

// Predicts keys from seeds under the current security constant and checks results in order.
class key_ledger;
  logic [31:0] sec_const;
  logic [31:0] expected_keys[$];
  int unsigned errors;
  int unsigned keys_checked;

  function new();
    sec_const    = s2k_pkg::ConstReset;
    errors       = 0;
    keys_checked = 0;
  endfunction

  // Byte pick, step count, LFSR walk, optional byte shuffle, final XOR
  function logic [31:0] derive_key(input logic [31:0] seed);
    logic [1:0]  sel;
    logic [7:0]  chosen;
    logic [7:0]  steps;
    logic [31:0] w;
    logic        fb;
    int          i;
    sel    = {sec_const[s2k_pkg::SelHiBit], sec_const[s2k_pkg::SelLoBit]};
    chosen = seed[8 * (3 - int'(sel)) +: 8];
    steps  = ((chosen ^ sec_const[9:2]) & (sec_const[30:23] ^ s2k_pkg::Mask2Xor))
             + (sec_const[20:13] ^ s2k_pkg::Mask3Xor);
    w = seed;
    for (i = 0; i < int'(steps); i++) begin
      fb = w[30] ^ w[24] ^ w[12] ^ w[2];
      w  = {w[30:0], fb};
    end
    if (sec_const[s2k_pkg::PermBit]) begin
      w = {w[15:8], w[31:24], w[7:0], w[23:16]};
    end
    return w ^ sec_const;
  endfunction

  function void note_seed(input logic [31:0] seed);
    expected_keys.push_back(derive_key(seed));
  endfunction

  function void check_key(input logic [31:0] actual);
    logic [31:0] want;
    keys_checked++;
    if (expected_keys.size() == 0) begin
      $error("key: no key expected, actual %08h", actual);
      errors++;
    end else begin
      want = expected_keys.pop_front();
      if (actual !== want) begin
        $error("key mismatch: expected %08h, actual %08h", want, actual);
        errors++;
      end
    end
  endfunction

  function int unsigned pending();
    return expected_keys.size();
  endfunction
endclass

module tb_seed_to_key_lfsr;

  // Register index 1 would sit here; the block has no such register, so writes must not land.
  localparam logic [s2k_pkg::CfgAddrW-1:0] SpareRegAddr = 3'd4;
  // Longest stretch without any transfer before the run is declared hung.
  localparam int unsigned IdleLimit    = 20000;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned PhaseItems   = 175;
  localparam int unsigned SettleCycles = 300;

  logic                         clk         = 1'b0;
  logic                         rst_n       = 1'b0;
  logic                         in_valid    = 1'b0;
  logic                         in_stall;
  logic [s2k_pkg::DataW-1:0]    in_seed     = '0;
  logic                         out_valid;
  logic                         out_stall   = 1'b0;
  logic [s2k_pkg::DataW-1:0]    out_key;
  logic                         cfg_psel    = 1'b0;
  logic                         cfg_penable = 1'b0;
  logic                         cfg_pwrite  = 1'b0;
  logic [s2k_pkg::CfgAddrW-1:0] cfg_paddr   = '0;
  logic [s2k_pkg::DataW-1:0]    cfg_pwdata  = '0;
  logic [s2k_pkg::DataW-1:0]    cfg_prdata;
  logic                         cfg_pready;

  key_ledger   ledger = new();
  bit          gaps_on = 1'b1;   // cleared for the gap-free stretch on both sides
  int unsigned seeds_sent = 0;
  int unsigned const_writes = 0;
  int unsigned stall_burst = 0;
  int unsigned idle_cycles = 0;

  seed_to_key_lfsr i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_seed     (in_seed),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_key     (out_key),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: check the transfer seen at this edge, then pick next cycle's stall.
  // Mostly single-cycle stalls, with rare long bursts so a finished key has to wait in the
  // sequencer behind a full output register.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      ledger.check_key(out_key);
    end
    if (!gaps_on) begin
      stall_burst = 0;
      out_stall <= 1'b0;
    end else if (stall_burst != 0) begin
      stall_burst--;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(1999) == 0) begin
        stall_burst = $urandom_range(100);
      end
      out_stall <= ($urandom_range(99) < 13);
    end
  end

  // Watchdog: counts edges with no transfer on any port
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $error("watchdog: no transfer for %0d cycles, %0d keys outstanding",
             idle_cycles, ledger.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Builds a constant from its fields; bits outside the fields come from fill
  function automatic logic [31:0] compose_const(input logic [7:0] m1, input logic [7:0] m2,
                                                input logic [7:0] m3, input logic [1:0] sel,
                                                input logic perm, input logic [31:0] fill);
    logic [31:0] c;
    c                    = fill;
    c[9:2]               = m1;
    c[30:23]             = m2 ^ s2k_pkg::Mask2Xor;
    c[20:13]             = m3 ^ s2k_pkg::Mask3Xor;
    c[s2k_pkg::SelHiBit] = sel[1];
    c[s2k_pkg::SelLoBit] = sel[0];
    c[s2k_pkg::PermBit]  = perm;
    return c;
  endfunction

  // Mostly uniform seeds, some all-zero (LFSR lockup word), all-one and lone-byte words
  function automatic logic [31:0] random_seed();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick == 2) return 32'hFF << (8 * $urandom_range(3));
    return $urandom();
  endfunction

  // One input transfer, optionally preceded by a gap of random length. Short gaps land while
  // the sequencer runs; long ones let it go idle first.
  task automatic send_seed(input logic [31:0] seed);
    int unsigned gap;
    if (gaps_on && $urandom_range(99) < 13) begin
      gap = $urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(1, 300);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_seed  <= seed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_seed(seed);
    seeds_sent++;
  endtask

  // Stop sending and wait until every key has come back
  task automatic drain_keys();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [s2k_pkg::CfgAddrW-1:0] addr, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == s2k_pkg::RegConstAddr) begin
      ledger.sec_const = value;
      const_writes++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Read the constant back and compare with what the ledger believes is active
  task automatic cfg_check_const();
    logic [31:0] got;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= s2k_pkg::RegConstAddr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== ledger.sec_const) begin
      $error("security_constant mismatch: expected %08h, actual %08h", ledger.sec_const, got);
      ledger.errors++;
    end
  endtask

  // New constant only once the block is empty; a wait after the drain covers the output register
  task automatic load_const(input logic [s2k_pkg::CfgAddrW-1:0] addr, input logic [31:0] value);
    drain_keys();
    repeat (8) @(posedge clk);
    cfg_write(addr, value);
    cfg_check_const();
  endtask

  logic [31:0] reset_seeds[12] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
    32'h4000_0000, 32'h0100_0000, 32'h0000_1000, 32'h0000_0004,
    32'h1234_5678, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFF00_00FF
  };

  initial begin
    logic [31:0] extremes[4];
    logic [31:0] c;
    int unsigned p;
    int unsigned k;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset constant, seeds hitting every tap, lockup word and the byte edges
    cfg_check_const();
    foreach (reset_seeds[k]) send_seed(reset_seeds[k]);

    // A write to a register that does not exist must leave the constant alone
    load_const(SpareRegAddr, 32'h0F0F_0F0F);

    // Extremes: all-zero and all-one constant, zero step count with byte shuffle,
    // full 255 steps without it
    extremes[0] = '0;
    extremes[1] = '1;
    extremes[2] = compose_const(8'($urandom), 8'h00, 8'h00, 2'($urandom), 1'b1, $urandom);
    extremes[3] = compose_const(8'($urandom), 8'h00, 8'hFF, 2'($urandom), 1'b0, $urandom);
    foreach (extremes[k]) begin
      load_const(s2k_pkg::RegConstAddr, extremes[k]);
      send_seed('0);
      send_seed('1);
      send_seed($urandom);
    end

    // Random phases, each under a fresh constant; the byte selector walks all four values.
    // Phase 2 runs with no idling on either side, phase 5 drains completely halfway.
    for (p = 0; p < RandomPhases; p++) begin
      c = compose_const(8'($urandom), 8'($urandom), 8'($urandom), 2'(p),
                        1'($urandom_range(1)), $urandom);
      load_const(s2k_pkg::RegConstAddr, c);
      gaps_on = (p != 2);
      for (k = 0; k < PhaseItems; k++) begin
        if (p == 5 && k == PhaseItems / 2) drain_keys();
        send_seed(random_seed());
      end
    end
    gaps_on = 1'b1;

    // Let everything drain, then watch a while longer for stray keys
    drain_keys();
    repeat (SettleCycles) @(posedge clk);

    $display("Run covered %0d seeds and %0d keys under %0d constant settings",
             seeds_sent, ledger.keys_checked, const_writes + 1);
    $display("Extremes, zero and full step counts, all byte selectors and both shuffle modes");
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
